// ===== sv/pls_pkg.sv =====
// Shared types and constants for the point light diffuse shader.
package pls_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int MAG_W      = COORD_W + 1;
    localparam int TOP_W      = $clog2(MAG_W);
    localparam int NORM_W     = 31;
    localparam int NRM_W      = 16;
    localparam int SQ_W       = 2 * NORM_W;
    localparam int LEN2_W     = 64;
    localparam int PR_W       = NORM_W + 1 + NRM_W;
    localparam int DOT_W      = PR_W + 2;
    localparam int LEN_W      = LEN2_W / 2;
    localparam int NUM_W      = DOT_W + 2;
    localparam int CS_W       = 21;
    localparam int CH_W       = 16;
    localparam int LUMEN_GAIN = 256;
    localparam int GAIN_W     = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMB_RED    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AMB_GREEN  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AMB_BLUE   = 3'd6;

    typedef struct packed {
        logic [CH_W-1:0] alb_r;
        logic [CH_W-1:0] alb_g;
        logic [CH_W-1:0] alb_b;
        logic            zero;
    } t_side;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        t_side                   side;
    } t_carry;

endpackage

// ===== sv/pls_dir.sv =====
// Light direction: difference, normalisation, squares and dot product (7 stages).
module pls_dir (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic signed [pls_pkg::COORD_W-1:0]   i_light [0:2],
    input  logic signed [pls_pkg::COORD_W-1:0]   i_hit [0:2],
    input  logic signed [pls_pkg::NRM_W-1:0]     i_normal [0:2],
    input  pls_pkg::t_side                       i_side,
    output logic                                 o_valid,
    output logic [pls_pkg::LEN2_W-1:0]           o_len2,
    output pls_pkg::t_carry                      o_carry
);

    logic [6:0] r_vld;

    logic signed [pls_pkg::DIFF_W-1:0] r1_d [0:2];
    logic [pls_pkg::MAG_W-1:0]         r2_mag [0:2];
    logic [pls_pkg::MAG_W-1:0]         r3_mag [0:2];
    logic [pls_pkg::MAG_W-1:0]         r4_mag [0:2];
    logic [pls_pkg::NORM_W-1:0]        r5_norm [0:2];
    logic [pls_pkg::SQ_W-1:0]          r6_sq [0:2];
    logic signed [pls_pkg::PR_W-1:0]   r6_pr [0:2];
    logic [2:0]                        r2_neg, r3_neg, r4_neg, r5_neg, r6_neg;
    logic [pls_pkg::MAG_W-1:0]         r3_max;
    logic [pls_pkg::TOP_W-1:0]         r4_top;
    logic signed [pls_pkg::NRM_W-1:0]  r1_n [0:2];
    logic signed [pls_pkg::NRM_W-1:0]  r2_n [0:2];
    logic signed [pls_pkg::NRM_W-1:0]  r3_n [0:2];
    logic signed [pls_pkg::NRM_W-1:0]  r4_n [0:2];
    logic signed [pls_pkg::NRM_W-1:0]  r5_n [0:2];
    pls_pkg::t_side                    r1_s, r2_s, r3_s, r4_s, r5_s, r6_s;
    logic [pls_pkg::LEN2_W-1:0]        r7_len2;
    pls_pkg::t_carry                   r7_c;

    logic [pls_pkg::MAG_W-1:0]         n_max;
    logic [pls_pkg::TOP_W-1:0]         n_top;
    logic [pls_pkg::MAG_W+pls_pkg::NORM_W-2:0] n_sh [0:2];
    logic [pls_pkg::LEN2_W-1:0]        n_len2;
    logic signed [pls_pkg::DOT_W-1:0]  n_dot;

    always_comb begin
        n_max = r2_mag[0];
        if (r2_mag[1] > n_max) begin
            n_max = r2_mag[1];
        end
        if (r2_mag[2] > n_max) begin
            n_max = r2_mag[2];
        end
        n_top = '0;
        for (int i = 0; i < pls_pkg::MAG_W; i++) begin
            if (r3_max[i]) begin
                n_top = pls_pkg::TOP_W'(i);
            end
        end
        for (int a = 0; a < 3; a++) begin
            n_sh[a] = {r4_mag[a], {(pls_pkg::NORM_W-1){1'b0}}} >> r4_top;
        end
        n_len2 = pls_pkg::LEN2_W'(r6_sq[0]) + pls_pkg::LEN2_W'(r6_sq[1])
               + pls_pkg::LEN2_W'(r6_sq[2]);
        n_dot = '0;
        for (int a = 0; a < 3; a++) begin
            if (r6_neg[a]) begin
                n_dot = n_dot - pls_pkg::DOT_W'(r6_pr[a]);
            end else begin
                n_dot = n_dot + pls_pkg::DOT_W'(r6_pr[a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 3; a++) begin
                r1_d[a] <= pls_pkg::DIFF_W'(i_light[a]) - pls_pkg::DIFF_W'(i_hit[a]);
                r1_n[a] <= i_normal[a];
                r2_neg[a] <= r1_d[a][pls_pkg::DIFF_W-1];
                r2_mag[a] <= r1_d[a][pls_pkg::DIFF_W-1] ? pls_pkg::MAG_W'(-r1_d[a])
                                                         : pls_pkg::MAG_W'(r1_d[a]);
                r2_n[a] <= r1_n[a];
                r3_mag[a] <= r2_mag[a];
                r3_n[a] <= r2_n[a];
                r4_mag[a] <= r3_mag[a];
                r4_n[a] <= r3_n[a];
                r5_norm[a] <= n_sh[a][pls_pkg::NORM_W-1:0];
                r5_n[a] <= r4_n[a];
                r6_sq[a] <= r5_norm[a] * r5_norm[a];
                r6_pr[a] <= $signed({{(pls_pkg::PR_W-pls_pkg::NORM_W){1'b0}}, r5_norm[a]})
                          * pls_pkg::PR_W'(r5_n[a]);
            end
            r1_s <= i_side;
            r2_s <= r1_s;
            r3_neg <= r2_neg;
            r3_max <= n_max;
            r3_s <= r2_s;
            r4_neg <= r3_neg;
            r4_top <= n_top;
            r4_s <= {r3_s.alb_r, r3_s.alb_g, r3_s.alb_b, r3_s.zero | (r3_max == '0)};
            r5_neg <= r4_neg;
            r5_s <= r4_s;
            r6_neg <= r5_neg;
            r6_s <= r5_s;
            r7_len2 <= n_len2;
            r7_c.dot <= n_dot;
            r7_c.side <= r6_s;
        end
    end

    assign o_valid = r_vld[6];
    assign o_len2  = r7_len2;
    assign o_carry = r7_c;

endmodule

// ===== sv/pls_sqrt.sv =====
// Integer square root, one result bit per stage (32 stages).
module pls_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [pls_pkg::LEN2_W-1:0]  i_x,
    input  pls_pkg::t_carry             i_carry,
    output logic                        o_valid,
    output logic [pls_pkg::LEN_W-1:0]   o_len,
    output pls_pkg::t_carry             o_carry
);

    localparam int STAGES = pls_pkg::LEN_W;

    logic [STAGES-1:0]          r_vld;
    logic [pls_pkg::LEN2_W-1:0] r_x [0:STAGES-1];
    logic [pls_pkg::LEN2_W-1:0] r_r [0:STAGES-1];
    pls_pkg::t_carry            r_c [0:STAGES-1];

    logic [pls_pkg::LEN2_W-1:0] n_x [0:STAGES-1];
    logic [pls_pkg::LEN2_W-1:0] n_r [0:STAGES-1];

    always_comb begin
        logic [pls_pkg::LEN2_W-1:0] x, r, b, t;
        for (int k = 0; k < STAGES; k++) begin
            x = (k == 0) ? i_x : r_x[(k == 0) ? 0 : k-1];
            r = (k == 0) ? '0  : r_r[(k == 0) ? 0 : k-1];
            b = pls_pkg::LEN2_W'(1) << (pls_pkg::LEN2_W - 2 - 2*k);
            t = r + b;
            if (x >= t) begin
                n_x[k] = x - t;
                n_r[k] = (r >> 1) + b;
            end else begin
                n_x[k] = x;
                n_r[k] = r >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < STAGES; k++) begin
                r_x[k] <= n_x[k];
                r_r[k] <= n_r[k];
                r_c[k] <= (k == 0) ? i_carry : r_c[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_len   = r_r[STAGES-1][pls_pkg::LEN_W-1:0];
    assign o_carry = r_c[STAGES-1];

endmodule

// ===== sv/pls_div.sv =====
// Cosine quotient 4*dot/len by restoring division, one quotient bit per stage.
module pls_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [pls_pkg::LEN_W-1:0]   i_len,
    input  pls_pkg::t_carry             i_carry,
    output logic                        o_valid,
    output logic [pls_pkg::CS_W-1:0]    o_cs,
    output pls_pkg::t_side              o_side
);

    localparam int STAGES = pls_pkg::CS_W;
    localparam int CMP_W  = pls_pkg::LEN_W + pls_pkg::CS_W;

    logic [STAGES-1:0]          r_vld;
    logic [pls_pkg::NUM_W-1:0]  r_rem [0:STAGES-1];
    logic [pls_pkg::LEN_W-1:0]  r_len [0:STAGES-1];
    logic [pls_pkg::CS_W-1:0]   r_q   [0:STAGES-1];
    pls_pkg::t_side             r_s   [0:STAGES-1];

    logic [pls_pkg::NUM_W-1:0]  n_rem [0:STAGES-1];
    logic [pls_pkg::CS_W-1:0]   n_q   [0:STAGES-1];
    pls_pkg::t_side             n_s0;

    always_comb begin
        logic [pls_pkg::NUM_W-1:0] rem;
        logic [pls_pkg::LEN_W-1:0] len;
        logic [pls_pkg::CS_W-1:0]  q;
        logic [CMP_W-1:0]          dvs;
        n_s0 = i_carry.side;
        n_s0.zero = i_carry.side.zero | (i_carry.dot <= 0) | (i_len == '0);
        for (int j = 0; j < STAGES; j++) begin
            if (j == 0) begin
                rem = pls_pkg::NUM_W'({i_carry.dot[pls_pkg::DOT_W-3:0], 2'b00});
                len = i_len;
                q   = '0;
            end else begin
                rem = r_rem[(j == 0) ? 0 : j-1];
                len = r_len[(j == 0) ? 0 : j-1];
                q   = r_q[(j == 0) ? 0 : j-1];
            end
            dvs = CMP_W'(len) << (STAGES - 1 - j);
            if (CMP_W'(rem) >= dvs) begin
                n_rem[j] = pls_pkg::NUM_W'(CMP_W'(rem) - dvs);
                q[STAGES-1-j] = 1'b1;
            end else begin
                n_rem[j] = rem;
            end
            n_q[j] = q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < STAGES; j++) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
                r_len[j] <= (j == 0) ? i_len : r_len[(j == 0) ? 0 : j-1];
                r_s[j]   <= (j == 0) ? n_s0  : r_s[(j == 0) ? 0 : j-1];
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_cs    = r_s[STAGES-1].zero ? '0 : r_q[STAGES-1];
    assign o_side  = r_s[STAGES-1];

endmodule

// ===== sv/pls_color.sv =====
// Per-channel diffuse, ambient, second albedo product and saturation (5 stages).
module pls_color (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [pls_pkg::CS_W-1:0]    i_cs,
    input  pls_pkg::t_side              i_side,
    input  logic [pls_pkg::CH_W-1:0]    i_bright,
    input  logic [pls_pkg::CH_W-1:0]    i_amb [0:2],
    output logic                        o_valid,
    output logic [pls_pkg::CH_W-1:0]    o_color [0:2]
);

    localparam int P1_W = pls_pkg::CH_W + pls_pkg::CS_W;
    localparam int P2_W = pls_pkg::CS_W + pls_pkg::CH_W;
    localparam int P3_W = P2_W + pls_pkg::GAIN_W;
    localparam int S_W  = P3_W - pls_pkg::CH_W + 1;
    localparam int P4_W = S_W + pls_pkg::CH_W;
    localparam int C_W  = P4_W - pls_pkg::CH_W;

    logic [4:0]                r_vld;
    logic [P1_W-1:0]           r1_p [0:2];
    logic [P2_W-1:0]           r2_p [0:2];
    logic [P3_W-1:0]           r3_p [0:2];
    logic [S_W-1:0]            r4_s [0:2];
    logic [P4_W-1:0]           r5_p [0:2];
    logic [pls_pkg::CH_W-1:0]  r1_a [0:2];
    logic [pls_pkg::CH_W-1:0]  r2_a [0:2];
    logic [pls_pkg::CH_W-1:0]  r3_a [0:2];
    logic [pls_pkg::CH_W-1:0]  r4_a [0:2];
    logic [pls_pkg::CH_W-1:0]  n_alb [0:2];
    logic [C_W-1:0]            n_col [0:2];

    always_comb begin
        n_alb[0] = i_side.alb_r;
        n_alb[1] = i_side.alb_g;
        n_alb[2] = i_side.alb_b;
        for (int c = 0; c < 3; c++) begin
            n_col[c] = r5_p[c][P4_W-1:pls_pkg::CH_W];
            o_color[c] = (n_col[c][C_W-1:pls_pkg::CH_W] != '0) ? '1
                                                                : n_col[c][pls_pkg::CH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r1_p[c] <= P1_W'(n_alb[c]) * P1_W'(i_cs);
                r1_a[c] <= n_alb[c];
                r2_p[c] <= P2_W'(r1_p[c][P1_W-1:pls_pkg::CH_W]) * P2_W'(i_bright);
                r2_a[c] <= r1_a[c];
                r3_p[c] <= P3_W'(r2_p[c]) * P3_W'(pls_pkg::LUMEN_GAIN);
                r3_a[c] <= r2_a[c];
                r4_s[c] <= S_W'(r3_p[c][P3_W-1:pls_pkg::CH_W]) + S_W'(i_amb[c]);
                r4_a[c] <= r3_a[c];
                r5_p[c] <= P4_W'(r4_s[c]) * P4_W'(r4_a[c]);
            end
        end
    end

    assign o_valid = r_vld[4];

endmodule

// ===== sv/point_light_diffuse_shader.sv =====
// Top level: configuration registers, shading pipeline and output skid stage.
// Takes one ray hit per clock cycle while s_axis_tready is high and returns one shaded
// colour per hit, in order. Each hit passes through direction and dot product, square
// root (one bit per stage), division (one quotient bit per stage), colour arithmetic
// and one output register. The output has a skid register, so a stalled result holds
// at most one further hit before s_axis_tready drops. Configuration writes are always
// ready and take effect at once.
module point_light_diffuse_shader (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [pls_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pls_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // hit_x, hit_y, hit_z, normal_x, normal_y, normal_z, albedo_red, albedo_green,
    // albedo_blue
    input  logic [191:0]                       s_axis_tdata,
    // in_shadow
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // color_red, color_green, color_blue
    output logic [47:0]                        m_axis_tdata
);

    logic signed [pls_pkg::COORD_W-1:0] r_light [0:2];
    logic [pls_pkg::CH_W-1:0]           r_bright;
    logic [pls_pkg::CH_W-1:0]           r_amb [0:2];

    logic                               r_out_valid, r_skid_valid;
    logic [47:0]                        r_out, r_skid;

    logic                               en, in_acc;
    logic signed [pls_pkg::COORD_W-1:0] hit [0:2];
    logic signed [pls_pkg::NRM_W-1:0]   nrm [0:2];
    pls_pkg::t_side                     side_in;

    logic                               dir_valid, sq_valid, dv_valid, col_valid;
    logic [pls_pkg::LEN2_W-1:0]         len2;
    pls_pkg::t_carry                    dir_c, sq_c;
    logic [pls_pkg::LEN_W-1:0]          len;
    logic [pls_pkg::CS_W-1:0]           cs;
    pls_pkg::t_side                     dv_side;
    logic [pls_pkg::CH_W-1:0]           color [0:2];
    logic [47:0]                        col_word;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light[0] <= '0;
            r_light[1] <= '0;
            r_light[2] <= '0;
            r_bright   <= '1;
            r_amb[0]   <= '0;
            r_amb[1]   <= '0;
            r_amb[2]   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pls_pkg::REG_LIGHT_X:    r_light[0] <= i_cfg_data;
                pls_pkg::REG_LIGHT_Y:    r_light[1] <= i_cfg_data;
                pls_pkg::REG_LIGHT_Z:    r_light[2] <= i_cfg_data;
                pls_pkg::REG_BRIGHTNESS: r_bright   <= i_cfg_data[pls_pkg::CH_W-1:0];
                pls_pkg::REG_AMB_RED:    r_amb[0]   <= i_cfg_data[pls_pkg::CH_W-1:0];
                pls_pkg::REG_AMB_GREEN:  r_amb[1]   <= i_cfg_data[pls_pkg::CH_W-1:0];
                pls_pkg::REG_AMB_BLUE:   r_amb[2]   <= i_cfg_data[pls_pkg::CH_W-1:0];
                default: ;
            endcase
        end
    end

    assign en            = !r_skid_valid;
    assign s_axis_tready = en;
    assign in_acc        = s_axis_tvalid && en;

    assign hit[0] = s_axis_tdata[31:0];
    assign hit[1] = s_axis_tdata[63:32];
    assign hit[2] = s_axis_tdata[95:64];
    assign nrm[0] = s_axis_tdata[111:96];
    assign nrm[1] = s_axis_tdata[127:112];
    assign nrm[2] = s_axis_tdata[143:128];
    assign side_in.alb_r = s_axis_tdata[159:144];
    assign side_in.alb_g = s_axis_tdata[175:160];
    assign side_in.alb_b = s_axis_tdata[191:176];
    assign side_in.zero  = s_axis_tuser;

    pls_dir u_dir (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(in_acc),
        .i_light(r_light), .i_hit(hit), .i_normal(nrm), .i_side(side_in),
        .o_valid(dir_valid), .o_len2(len2), .o_carry(dir_c)
    );

    pls_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(dir_valid),
        .i_x(len2), .i_carry(dir_c),
        .o_valid(sq_valid), .o_len(len), .o_carry(sq_c)
    );

    pls_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(sq_valid),
        .i_len(len), .i_carry(sq_c),
        .o_valid(dv_valid), .o_cs(cs), .o_side(dv_side)
    );

    pls_color u_color (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(dv_valid),
        .i_cs(cs), .i_side(dv_side), .i_bright(r_bright), .i_amb(r_amb),
        .o_valid(col_valid), .o_color(color)
    );

    assign col_word = {color[2], color[1], color[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (en) begin
            if (col_valid && r_out_valid && !m_axis_tready) begin
                r_skid_valid <= 1'b1;
            end else if (col_valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end else if (m_axis_tready) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (col_valid && r_out_valid && !m_axis_tready) begin
                r_skid <= col_word;
            end else if (col_valid) begin
                r_out <= col_word;
            end
        end else if (m_axis_tready) begin
            r_out <= r_skid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !m_axis_tready))
        else $error("skid filled without an output stall");

    a_stall_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !m_axis_tready |=> r_skid_valid && $stable(r_skid))
        else $error("skid content lost during stall");

endmodule

// ===== tb/tb_checker.sv =====
// Checker for the diffuse shader: watches both streams and the config channel, predicts colours.
module tb_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_hit_valid,
    input  logic         i_hit_ready,
    input  logic [191:0] i_hit_data,
    input  logic         i_hit_shadow,
    input  logic         i_col_valid,
    input  logic         i_col_ready,
    input  logic [47:0]  i_col_data,
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0] light_x, light_y, light_z;
    logic [15:0] brightness, amb_r, amb_g, amb_b;
    logic [47:0] colour_q[$];

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] lambert_cos(logic [191:0] h);
        logic signed [63:0] d, dot, n, t;
        logic [63:0] mag[3], m, len2, len;
        logic        neg[3];
        int          top;
        m = 0;
        dot = 0;
        len2 = 0;
        top = 0;
        for (int i = 0; i < 3; i++) begin
            d = $signed(i == 0 ? light_x : i == 1 ? light_y : light_z)
              - $signed(h[32*i +: 32]);
            neg[i] = d < 0;
            mag[i] = neg[i] ? -d : d;
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 0;
        while ((m >> top) > 1) top++;
        for (int i = 0; i < 3; i++) begin
            if (top > 30) mag[i] = mag[i] >> (top - 30);
            else mag[i] = mag[i] << (30 - top);
            len2 = len2 + mag[i] * mag[i];
        end
        len = root_floor(len2);
        for (int i = 0; i < 3; i++) begin
            n = $signed(h[96 + 16*i +: 16]);
            t = n * $signed(mag[i]);
            dot = neg[i] ? dot - t : dot + t;
        end
        if (dot <= 0 || len == 0) return 0;
        return (dot << 2) / len;
    endfunction

    function automatic logic [47:0] shade_hit(logic [191:0] h, logic shadow);
        logic [63:0] cs, alb, amb, diff, col;
        logic [47:0] res;
        cs = shadow ? 64'd0 : lambert_cos(h);
        for (int c = 0; c < 3; c++) begin
            alb = h[144 + 16*c +: 16];
            amb = c == 0 ? amb_r : c == 1 ? amb_g : amb_b;
            diff = (((alb * cs) >> 16) * brightness * pls_pkg::LUMEN_GAIN) >> 16;
            col = ((diff + amb) * alb) >> 16;
            res[16*c +: 16] = col > 65535 ? 16'hFFFF : col[15:0];
        end
        return res;
    endfunction

    string chan_name[3] = '{"color_red", "color_green", "color_blue"};

    always @(posedge i_clk) begin
        logic [47:0] want;
        if (!i_rst_n) begin
            light_x <= 0;
            light_y <= 0;
            light_z <= 0;
            brightness <= 16'hFFFF;
            amb_r <= 0;
            amb_g <= 0;
            amb_b <= 0;
        end else begin
            if (i_hit_valid && i_hit_ready)
                colour_q.push_back(shade_hit(i_hit_data, i_hit_shadow));
            if (i_col_valid && i_col_ready) begin
                if (colour_q.size() == 0) begin
                    $error("colour transaction with nothing expected");
                    o_errors++;
                end else begin
                    want = colour_q.pop_front();
                    for (int c = 0; c < 3; c++)
                        if (want[16*c +: 16] !== i_col_data[16*c +: 16]) begin
                            $error("%s expected %0d actual %0d", chan_name[c],
                                   want[16*c +: 16], i_col_data[16*c +: 16]);
                            o_errors++;
                        end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pls_pkg::REG_LIGHT_X:    light_x <= i_cfg_data;
                    pls_pkg::REG_LIGHT_Y:    light_y <= i_cfg_data;
                    pls_pkg::REG_LIGHT_Z:    light_z <= i_cfg_data;
                    pls_pkg::REG_BRIGHTNESS: brightness <= i_cfg_data[15:0];
                    pls_pkg::REG_AMB_RED:    amb_r <= i_cfg_data[15:0];
                    pls_pkg::REG_AMB_GREEN:  amb_g <= i_cfg_data[15:0];
                    pls_pkg::REG_AMB_BLUE:   amb_b <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
        o_pending <= colour_q.size();
    end

    initial o_errors = 0;
endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the diffuse shader: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         cfg_valid = 0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = 0;
    logic [31:0]  cfg_data = 0;
    logic         hit_valid = 0;
    logic         hit_ready;
    logic [191:0] hit_data = 0;
    logic         hit_shadow = 0;
    logic         col_valid;
    logic         col_ready = 0;
    logic [47:0]  col_data;
    int           errors, pending;
    int           idle_cycles = 0;
    bit           busy_mode = 1;
    bit           hold_off = 0;

    always #4 i_clk = ~i_clk;

    point_light_diffuse_shader i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .s_axis_tvalid(hit_valid), .s_axis_tready(hit_ready),
        .s_axis_tdata(hit_data), .s_axis_tuser(hit_shadow),
        .m_axis_tvalid(col_valid), .m_axis_tready(col_ready), .m_axis_tdata(col_data)
    );

    tb_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_hit_valid(hit_valid), .i_hit_ready(hit_ready),
        .i_hit_data(hit_data), .i_hit_shadow(hit_shadow),
        .i_col_valid(col_valid), .i_col_ready(col_ready), .i_col_data(col_data),
        .o_errors(errors), .o_pending(pending)
    );

    // receiver: random stalls, optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off) col_ready <= 0;
        else col_ready <= busy_mode ? 1'b1 : ($urandom_range(99) >= 29);
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((hit_valid && hit_ready) || (col_valid && col_ready) || pending == 0)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 0;
    endtask

    task automatic send_hit(logic [191:0] d, logic sh);
        if (!busy_mode)
            while ($urandom_range(99) < 29) begin
                hit_valid <= 0;
                @(posedge i_clk);
            end
        hit_valid <= 1;
        hit_data <= d;
        hit_shadow <= sh;
        do @(posedge i_clk); while (!hit_ready);
    endtask

    function automatic logic [15:0] rnd_normal();
        int v;
        v = $urandom_range(3) == 0 ? ($urandom_range(2) * 16384 - 16384)
                                   : ($urandom_range(32768) - 16384);
        return v[15:0];
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $signed($urandom_range(40 << 16)) - (20 << 16);
        endcase
    endfunction

    function automatic logic [15:0] rnd_chan();
        case ($urandom_range(3))
            0:       return 16'hFFFF;
            1:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [191:0] make_hit(logic [31:0] x, y, z, logic [15:0] nx, ny, nz,
                                              logic [15:0] r, g, b);
        return {b, g, r, nz, ny, nx, z, y, x};
    endfunction

    task automatic drain();
        hit_valid <= 0;
        while (pending != 0 || hit_valid) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic random_cfg(bit extreme);
        write_reg(pls_pkg::REG_LIGHT_X, extreme ? 32'h8000_0000 : rnd_coord());
        write_reg(pls_pkg::REG_LIGHT_Y, extreme ? 32'h7FFF_FFFF : rnd_coord());
        write_reg(pls_pkg::REG_LIGHT_Z, rnd_coord());
        write_reg(pls_pkg::REG_BRIGHTNESS, extreme ? 32'h0 : {16'h0, rnd_chan()});
        write_reg(pls_pkg::REG_AMB_RED, {16'h0, rnd_chan()});
        write_reg(pls_pkg::REG_AMB_GREEN, extreme ? 32'hFFFF : {16'h0, rnd_chan()});
        write_reg(pls_pkg::REG_AMB_BLUE, $urandom);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed, reset config: light at origin
        send_hit(make_hit(0, 0, 0, 16384, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
        send_hit(make_hit(32'hFFFF_0000, 0, 0, 16384, 0, 0, 16'hFFFF, 16'h8000, 0), 0);
        send_hit(make_hit(32'hFFFF_0000, 0, 0, 16384, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1);
        send_hit(make_hit(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hC000, 16'hC000,
                          16'hC000, 16'hFFFF, 16'h1234, 16'h0001), 0);
        send_hit(make_hit(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16384, 16384, 16384,
                          16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
        send_hit(make_hit(0, 32'h0001_0000, 0, 0, 16384, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
        send_hit(make_hit(0, 0, 32'h0000_0001, 0, 0, 16'hC000, 16'h0000, 16'hFFFF, 16'h4000), 0);
        drain();
        write_reg(pls_pkg::REG_AMB_RED, 32'hFFFF);
        write_reg(pls_pkg::REG_AMB_GREEN, 32'h8000);
        write_reg(pls_pkg::REG_AMB_BLUE, 32'h0);
        write_reg(pls_pkg::REG_BRIGHTNESS, 32'h0);
        write_reg(pls_pkg::REG_LIGHT_X, 32'h7FFF_FFFF);
        write_reg(pls_pkg::REG_LIGHT_Y, 32'h8000_0000);
        write_reg(pls_pkg::REG_LIGHT_Z, 32'h0001_0000);
        send_hit(make_hit(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 16384, 0, 0,
                          16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
        send_hit(make_hit(32'h8000_0000, 32'h7FFF_FFFF, 0, 16384, 16'hC000, 16384,
                          16'hFFFF, 16'h8000, 16'h0001), 1);
        send_hit(make_hit(0, 0, 0, 16384, 16'hC000, 16384, 16'hFFFF, 16'hFFFF, 16'hFFFF), 0);
        drain();

        // random phases with pressure in the first
        for (int ph = 0; ph < 8; ph++) begin
            random_cfg(ph == 1);
            busy_mode = (ph == 2);
            if (ph == 0) begin
                hold_off = 1;
                fork
                    begin
                        repeat (300) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            for (int n = 0; n < 250; n++)
                send_hit(make_hit(rnd_coord(), rnd_coord(), rnd_coord(), rnd_normal(),
                                  rnd_normal(), rnd_normal(), rnd_chan(), rnd_chan(),
                                  rnd_chan()), $urandom_range(4) == 0);
            drain();
        end

        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule
